// ===== hw/rtl/ivbs_pkg.sv =====
// types, constants and corner table shared by the box-sum volume block
`default_nettype none

package ivbs_pkg;

  localparam int unsigned EXT_W       = 6;
  localparam int unsigned COORD_W     = 5;
  localparam int unsigned LOW_W       = 6;
  localparam int unsigned IDX_W       = 15;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned WH_W        = 2 * EXT_W;
  localparam int unsigned LIN_W       = 18;
  localparam int unsigned REG_IDX_W   = 8;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned CNT_W       = 3;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CORNERS - 1);

  localparam logic [REG_IDX_W-1:0] REG_VOLUME_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_VOLUME_HEIGHT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_VOLUME_LENGTH = REG_IDX_W'(2);

  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(32);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [EXT_W-1:0] w;
    logic [EXT_W-1:0] h;
    logic [EXT_W-1:0] l;
    logic [WH_W-1:0]  wh;
  } cfg_t;

  typedef struct packed {
    logic hi_x;
    logic hi_y;
    logic hi_z;
    logic neg;
  } corner_t;

  // inclusion-exclusion order of the eight corners
  function automatic corner_t corner_sel(input logic [CNT_W-1:0] k);
    corner_t c;
    unique case (k)
      3'd0: c = corner_t'(4'b1110);
      3'd1: c = corner_t'(4'b0010);
      3'd2: c = corner_t'(4'b0100);
      3'd3: c = corner_t'(4'b1000);
      3'd4: c = corner_t'(4'b1011);
      3'd5: c = corner_t'(4'b0111);
      3'd6: c = corner_t'(4'b1101);
      3'd7: c = corner_t'(4'b0001);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/integral_volume_box_sum.sv =====
// 3d summed volume table with eight-corner box sum queries
// load item: accepted when idle, written into the table as it is accepted, gives no result
// query item: eight corner reads on the single table port, one per cycle, then the result register is
//   loaded once it is empty or being read out; the next item is taken after that load
// invalid box: no corner reads; the result register is loaded from the done state with a zero sum
// reset: extents return to 32 (saturated to the maximum); table contents are kept undefined
`default_nettype none

module integral_volume_box_sum #(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned MAX_HEIGHT = 32,
  parameter int unsigned MAX_LENGTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ivbs_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [ivbs_pkg::EXT_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [ivbs_pkg::IDX_W-1:0]         entry_index_i,
  input  logic signed [ivbs_pkg::DATA_W-1:0] entry_value_i,
  input  logic [ivbs_pkg::LOW_W-1:0]         x_low_i,
  input  logic [ivbs_pkg::LOW_W-1:0]         y_low_i,
  input  logic [ivbs_pkg::LOW_W-1:0]         z_low_i,
  input  logic [ivbs_pkg::COORD_W-1:0]       x_high_i,
  input  logic [ivbs_pkg::COORD_W-1:0]       y_high_i,
  input  logic [ivbs_pkg::COORD_W-1:0]       z_high_i,
  input  logic                               last_query_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ivbs_pkg::DATA_W-1:0] box_sum_o,
  output logic                               range_error_o,
  output logic                               last_result_o
);
  import ivbs_pkg::*;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_LENGTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  cfg_t              cfg;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  ivbs_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ivbs_seq #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .x_low_i       (x_low_i),
    .y_low_i       (y_low_i),
    .z_low_i       (z_low_i),
    .x_high_i      (x_high_i),
    .y_high_i      (y_high_i),
    .z_high_i      (z_high_i),
    .last_query_i  (last_query_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .box_sum_o     (box_sum_o),
    .range_error_o (range_error_o),
    .last_result_o (last_result_o),
    .cfg_i         (cfg),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  ivbs_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ivbs_cfg.sv =====
// volume extent registers and the precomputed plane size
`default_nettype none

module ivbs_cfg #(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned MAX_HEIGHT = 32,
  parameter int unsigned MAX_LENGTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ivbs_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [ivbs_pkg::EXT_W-1:0]       cfg_data_i,
  output ivbs_pkg::cfg_t                   cfg_o
);
  import ivbs_pkg::*;

  function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v,
                                                 input int unsigned maxv);
    logic [EXT_W-1:0] r;
    if (32'(v) > maxv) r = EXT_W'(maxv);
    else r = v;
    return r;
  endfunction

  localparam logic [EXT_W-1:0] W_RST  = clamp_ext(EXT_RESET, MAX_WIDTH);
  localparam logic [EXT_W-1:0] H_RST  = clamp_ext(EXT_RESET, MAX_HEIGHT);
  localparam logic [EXT_W-1:0] L_RST  = clamp_ext(EXT_RESET, MAX_LENGTH);
  localparam logic [WH_W-1:0]  WH_RST = WH_W'(32'(W_RST) * 32'(H_RST));

  logic [EXT_W-1:0] w_q, w_d, h_q, h_d, l_q, l_d;
  logic [WH_W-1:0]  wh_q, wh_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    w_d  = w_q;
    h_d  = h_q;
    l_d  = l_q;
    wh_d = {{EXT_W{1'b0}}, w_q} * {{EXT_W{1'b0}}, h_q};
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VOLUME_WIDTH:  w_d = clamp_ext(cfg_data_i, MAX_WIDTH);
        REG_VOLUME_HEIGHT: h_d = clamp_ext(cfg_data_i, MAX_HEIGHT);
        REG_VOLUME_LENGTH: l_d = clamp_ext(cfg_data_i, MAX_LENGTH);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= W_RST;
      h_q  <= H_RST;
      l_q  <= L_RST;
      wh_q <= WH_RST;
    end else begin
      w_q  <= w_d;
      h_q  <= h_d;
      l_q  <= l_d;
      wh_q <= wh_d;
    end
  end

  assign cfg_o.w  = w_q;
  assign cfg_o.h  = h_q;
  assign cfg_o.l  = l_q;
  assign cfg_o.wh = wh_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ivbs_store.sv =====
// single-port summed volume table with registered read data
`default_nettype none

module ivbs_store #(
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned ADDR_W = 15
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic                           re_i,
  input  logic [ADDR_W-1:0]              addr_i,
  input  logic [ivbs_pkg::DATA_W-1:0]    wdata_i,
  output logic [ivbs_pkg::DATA_W-1:0]    rdata_o
);
  import ivbs_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ivbs_seq.sv =====
// query sequencer: range check, corner addressing, accumulation and result register
`default_nettype none

module ivbs_seq #(
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned ADDR_W = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [ivbs_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [ivbs_pkg::DATA_W-1:0] entry_value_i,
  input  logic [ivbs_pkg::LOW_W-1:0]        x_low_i,
  input  logic [ivbs_pkg::LOW_W-1:0]        y_low_i,
  input  logic [ivbs_pkg::LOW_W-1:0]        z_low_i,
  input  logic [ivbs_pkg::COORD_W-1:0]      x_high_i,
  input  logic [ivbs_pkg::COORD_W-1:0]      y_high_i,
  input  logic [ivbs_pkg::COORD_W-1:0]      z_high_i,
  input  logic                              last_query_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ivbs_pkg::DATA_W-1:0] box_sum_o,
  output logic                              range_error_o,
  output logic                              last_result_o,
  input  ivbs_pkg::cfg_t                    cfg_i,
  output logic                              mem_we_o,
  output logic                              mem_re_o,
  output logic [ADDR_W-1:0]                 mem_addr_o,
  output logic [ivbs_pkg::DATA_W-1:0]       mem_wdata_o,
  input  logic [ivbs_pkg::DATA_W-1:0]       mem_rdata_i
);
  import ivbs_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COORD_W-1:0] xh_q, yh_q, zh_q, xl1_q, yl1_q, zl1_q;
  logic               err_q, last_q;
  logic [DATA_W-1:0]  acc_q, acc_d;
  logic               rd_vld_q, rd_neg_q;
  logic               out_valid_q, out_err_q, out_last_q;
  logic [DATA_W-1:0]  out_sum_q;

  logic               in_acc, query_acc, bad, out_load;
  corner_t            cs;
  logic [COORD_W-1:0] cx, cy, cz;
  logic [LIN_W-1:0]   lin;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign query_acc  = in_acc & (op_i == OP_QUERY);

  always_comb begin
    bad = (x_low_i == '0) | (y_low_i == '0) | (z_low_i == '0)
        | ({1'b0, x_high_i} < x_low_i) | ({1'b0, y_high_i} < y_low_i)
        | ({1'b0, z_high_i} < z_low_i)
        | ({1'b0, x_high_i} >= cfg_i.w) | ({1'b0, y_high_i} >= cfg_i.h)
        | ({1'b0, z_high_i} >= cfg_i.l);
  end

  // corner address x + y*W + z*W*H
  always_comb begin
    cs  = corner_sel(cnt_q);
    cx  = cs.hi_x ? xh_q : xl1_q;
    cy  = cs.hi_y ? yh_q : yl1_q;
    cz  = cs.hi_z ? zh_q : zl1_q;
    lin = LIN_W'(cx) + LIN_W'(cy) * LIN_W'(cfg_i.w) + LIN_W'(cz) * LIN_W'(cfg_i.wh);
  end

  assign mem_re_o    = (state_q == S_READ);
  assign mem_we_o    = in_acc & (op_i == OP_LOAD) & (32'(entry_index_i) < DEPTH);
  assign mem_addr_o  = mem_re_o ? ADDR_W'(lin) : ADDR_W'(entry_index_i);
  assign mem_wdata_o = entry_value_i;

  assign out_load = (state_q == S_DONE) & (~out_valid_q | ~out_stall_i);
  assign acc_d    = rd_neg_q ? (acc_q - mem_rdata_i) : (acc_q + mem_rdata_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (query_acc) state_d = bad ? S_DONE : S_READ;
      end
      S_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) state_d = S_LAST;
      end
      S_LAST: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= mem_re_o;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_neg_q <= cs.neg;
    if (query_acc) begin
      xh_q   <= x_high_i;
      yh_q   <= y_high_i;
      zh_q   <= z_high_i;
      xl1_q  <= COORD_W'(x_low_i - 1'b1);
      yl1_q  <= COORD_W'(y_low_i - 1'b1);
      zl1_q  <= COORD_W'(z_low_i - 1'b1);
      err_q  <= bad;
      last_q <= last_query_i;
      acc_q  <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_d;
    end
    if (out_load) begin
      out_sum_q  <= acc_q;
      out_err_q  <= err_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign box_sum_o     = $signed(out_sum_q);
  assign range_error_o = out_err_q;
  assign last_result_o = out_last_q;

`ifndef SYNTH
  a_no_read_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_LAST) |-> !err_q)
    else $error("corner reads issued for an invalid box");

  a_eight_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |-> ($past(state_q) == S_READ && $past(cnt_q) == CNT_LAST))
    else $error("read phase ended before all corners");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the done phase");

  a_write_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (!mem_re_o && !rd_vld_q))
    else $error("table write collides with a corner read");

  a_error_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> out_sum_q == '0)
    else $error("invalid box gave a non-zero sum");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/integral_volume_box_sum_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the summed volume box sum block: loads, box queries, extents
module integral_volume_box_sum_tb;
  import ivbs_pkg::*;

  localparam int unsigned STORE_DEPTH    = 32768;
  localparam int unsigned MAX_EXT        = 32;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned NUM_DIRECTED   = 21;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = '1;

  typedef struct packed {
    logic                op;
    logic [IDX_W-1:0]    entry_index;
    logic [DATA_W-1:0]   entry_value;
    logic [LOW_W-1:0]    x_low;
    logic [LOW_W-1:0]    y_low;
    logic [LOW_W-1:0]    z_low;
    logic [COORD_W-1:0]  x_high;
    logic [COORD_W-1:0]  y_high;
    logic [COORD_W-1:0]  z_high;
    logic                last;
  } box_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              err;
    logic              last;
  } box_result_t;

  typedef struct packed {
    box_item_t   item;
    logic        known;
    box_result_t res;
  } stim_row_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [REG_IDX_W-1:0]       cfg_index_i   = '0;
  logic [EXT_W-1:0]           cfg_data_i    = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic                       op_i          = OP_LOAD;
  logic [IDX_W-1:0]           entry_index_i = '0;
  logic signed [DATA_W-1:0]   entry_value_i = '0;
  logic [LOW_W-1:0]           x_low_i       = '0;
  logic [LOW_W-1:0]           y_low_i       = '0;
  logic [LOW_W-1:0]           z_low_i       = '0;
  logic [COORD_W-1:0]         x_high_i      = '0;
  logic [COORD_W-1:0]         y_high_i      = '0;
  logic [COORD_W-1:0]         z_high_i      = '0;
  logic                       last_query_i  = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic signed [DATA_W-1:0]   box_sum_o;
  logic                       range_error_o;
  logic                       last_result_o;

  integral_volume_box_sum u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .x_low_i       (x_low_i),
    .y_low_i       (y_low_i),
    .z_low_i       (z_low_i),
    .x_high_i      (x_high_i),
    .y_high_i      (y_high_i),
    .z_high_i      (z_high_i),
    .last_query_i  (last_query_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .box_sum_o     (box_sum_o),
    .range_error_o (range_error_o),
    .last_result_o (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  logic [DATA_W-1:0] vol_store [0:STORE_DEPTH-1];
  bit                vol_written [0:STORE_DEPTH-1];
  logic [EXT_W-1:0]  ext_w = EXT_W'(MAX_EXT);
  logic [EXT_W-1:0]  ext_h = EXT_W'(MAX_EXT);
  logic [EXT_W-1:0]  ext_l = EXT_W'(MAX_EXT);

  box_result_t pending_sums [$];
  box_result_t want;
  stim_row_t   directed_rows [0:NUM_DIRECTED-1];

  bit          rx_hold_req = 1'b0;
  bit          quiet_tail  = 1'b0;
  int unsigned mismatches        = 0;
  int unsigned items_sent        = 0;
  int unsigned loads_sent        = 0;
  int unsigned queries_sent      = 0;
  int unsigned results_checked   = 0;
  int unsigned range_errors_seen = 0;
  int unsigned settings_used     = 0;
  int unsigned quiet_cycles      = 0;

  function automatic bit box_is_bad(input box_item_t it);
    return it.x_low == 0 || it.y_low == 0 || it.z_low == 0
        || it.x_high < it.x_low || it.y_high < it.y_low || it.z_high < it.z_low
        || it.x_high >= ext_w || it.y_high >= ext_h || it.z_high >= ext_l;
  endfunction

  // bit 0, 1, 2 of the corner number pick the high x, y, z coordinate
  function automatic int unsigned corner_addr(input box_item_t it, input logic [2:0] sel);
    int unsigned x;
    int unsigned y;
    int unsigned z;
    x = sel[0] ? it.x_high : it.x_low - 1;
    y = sel[1] ? it.y_high : it.y_low - 1;
    z = sel[2] ? it.z_high : it.z_low - 1;
    return x + y * ext_w + z * ext_w * ext_h;
  endfunction

  function automatic box_result_t box_sum_of(input box_item_t it);
    box_result_t r;
    logic [DATA_W-1:0] acc;
    logic [2:0] sel;
    acc = '0;
    r.err = box_is_bad(it);
    if (!r.err) begin
      for (int k = 0; k < 8; k++) begin
        sel = k[2:0];
        // an odd count of high coordinates adds, an even count subtracts
        if ($countones(sel) % 2 == 1) begin
          acc = acc + vol_store[corner_addr(it, sel)];
        end else begin
          acc = acc - vol_store[corner_addr(it, sel)];
        end
      end
    end
    r.sum = acc;
    r.last = it.last;
    return r;
  endfunction

  function automatic box_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(box_item_t)-1:0];
  endfunction

  function automatic stim_row_t load_row(input int unsigned idx, input logic [DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.item.op = OP_LOAD;
    r.item.entry_index = IDX_W'(idx);
    r.item.entry_value = val;
    return r;
  endfunction

  function automatic stim_row_t box_row(input int unsigned xl, yl, zl, xh, yh, zh,
                                        input bit last, input bit known);
    stim_row_t r;
    r = '0;
    r.item.op = OP_QUERY;
    r.item.x_low = LOW_W'(xl);
    r.item.y_low = LOW_W'(yl);
    r.item.z_low = LOW_W'(zl);
    r.item.x_high = COORD_W'(xh);
    r.item.y_high = COORD_W'(yh);
    r.item.z_high = COORD_W'(zh);
    r.item.last = last;
    r.known = known;
    r.res.err = known;
    r.res.last = last;
    return r;
  endfunction

  function automatic int unsigned pick_high(input int unsigned ext);
    if ($urandom_range(0, 1) == 0) begin
      return $urandom_range(1, (ext > 4) ? 3 : ext - 1);
    end
    return $urandom_range(1, ext - 1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_item(input box_item_t it, input bit known, input box_result_t fixed);
    if (it.op == OP_LOAD) begin
      vol_store[it.entry_index] = it.entry_value;
      vol_written[it.entry_index] = 1'b1;
      loads_sent++;
    end else begin
      pending_sums.push_back(known ? fixed : box_sum_of(it));
      queries_sent++;
    end
    items_sent++;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    op_i          <= it.op;
    entry_index_i <= it.entry_index;
    entry_value_i <= it.entry_value;
    x_low_i       <= it.x_low;
    y_low_i       <= it.y_low;
    z_low_i       <= it.z_low;
    x_high_i      <= it.x_high;
    y_high_i      <= it.y_high;
    z_high_i      <= it.z_high;
    last_query_i  <= it.last;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // corners never written are loaded first so that no query reads undefined entries
  task automatic ask_box(input box_item_t q);
    box_item_t ld;
    int unsigned addr;
    if (!box_is_bad(q)) begin
      for (int k = 0; k < 8; k++) begin
        addr = corner_addr(q, k[2:0]);
        if (!vol_written[addr]) begin
          ld = random_item();
          ld.op = OP_LOAD;
          ld.entry_index = IDX_W'(addr);
          send_item(ld, 1'b0, '0);
        end
      end
    end
    send_item(q, 1'b0, '0);
  endtask

  task automatic write_extent(input logic [REG_IDX_W-1:0] idx, input logic [EXT_W-1:0] val);
    logic [EXT_W-1:0] sat;
    sat = (val > MAX_EXT) ? EXT_W'(MAX_EXT) : val;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_VOLUME_WIDTH: begin
        ext_w = sat;
      end
      REG_VOLUME_HEIGHT: begin
        ext_h = sat;
      end
      REG_VOLUME_LENGTH: begin
        ext_l = sat;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_extents(input logic [EXT_W-1:0] w, h, l);
    write_extent(REG_VOLUME_WIDTH, w);
    write_extent(REG_VOLUME_HEIGHT, h);
    write_extent(REG_VOLUME_LENGTH, l);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n_items, input bit with_hold, input bit tail);
    box_item_t it;
    int unsigned start;
    int unsigned pick;
    int unsigned x;
    int unsigned y;
    int unsigned z;
    bit held;
    start = items_sent;
    held = 1'b0;
    while (items_sent - start < n_items) begin
      if (with_hold && !held && items_sent - start > n_items / 2) begin
        rx_hold_req = 1'b1;
        held = 1'b1;
      end
      if (tail && items_sent - start > n_items / 2) begin
        quiet_tail = 1'b1;
      end
      pick = $urandom_range(0, 99);
      it = random_item();
      if (pick < 35) begin
        it.op = OP_LOAD;
        if (pick < 18 && ext_w != 0 && ext_h != 0 && ext_l != 0) begin
          x = $urandom_range(0, ext_w - 1);
          y = $urandom_range(0, ext_h - 1);
          z = $urandom_range(0, ext_l - 1);
          it.entry_index = IDX_W'(x + y * ext_w + z * ext_w * ext_h);
        end
        send_item(it, 1'b0, '0);
      end else begin
        it.op = OP_QUERY;
        if (pick < 88 && ext_w >= 2 && ext_h >= 2 && ext_l >= 2) begin
          it.x_high = COORD_W'(pick_high(ext_w));
          it.y_high = COORD_W'(pick_high(ext_h));
          it.z_high = COORD_W'(pick_high(ext_l));
          it.x_low  = LOW_W'($urandom_range(1, it.x_high));
          it.y_low  = LOW_W'($urandom_range(1, it.y_high));
          it.z_low  = LOW_W'($urandom_range(1, it.z_high));
        end
        ask_box(it);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (range_error_o === 1'b1) begin
        range_errors_seen++;
      end
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, sum %h", box_sum_o));
      end else begin
        want = pending_sums.pop_front();
        if (box_sum_o !== want.sum) begin
          report_mismatch($sformatf("box_sum %h, expected %h", box_sum_o, want.sum));
        end
        if (range_error_o !== want.err) begin
          report_mismatch($sformatf("range_error %b, expected %b", range_error_o, want.err));
        end
        if (last_result_o !== want.last) begin
          report_mismatch($sformatf("last_result %b, expected %b", last_result_o, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts, one long hold on request, none in the tail
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    directed_rows = '{
      load_row(0,     32'h7fff_ffff),
      load_row(31,    32'h8000_0000),
      load_row(992,   32'hffff_ffff),
      load_row(1023,  32'h0000_0000),
      load_row(31744, 32'h0000_0100),
      load_row(31775, 32'hffff_fe00),
      load_row(32736, 32'h5555_5555),
      load_row(32767, 32'haaaa_aaaa),
      box_row(1, 1, 1, 31, 31, 31, 1'b0, 1'b0),
      box_row(1, 1, 1, 1, 1, 1, 1'b1, 1'b0),
      box_row(31, 31, 31, 31, 31, 31, 1'b0, 1'b0),
      box_row(0, 1, 1, 5, 5, 5, 1'b0, 1'b1),
      box_row(1, 0, 1, 5, 5, 5, 1'b1, 1'b1),
      box_row(1, 1, 0, 5, 5, 5, 1'b0, 1'b1),
      box_row(6, 1, 1, 5, 5, 5, 1'b1, 1'b1),
      box_row(1, 63, 1, 5, 31, 5, 1'b0, 1'b1),
      box_row(1, 1, 32, 5, 5, 31, 1'b1, 1'b1),
      box_row(63, 63, 63, 31, 31, 31, 1'b1, 1'b1),
      box_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b1),
      box_row(1, 1, 1, 0, 0, 0, 1'b1, 1'b1),
      box_row(2, 3, 4, 20, 17, 9, 1'b1, 1'b0)
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].item.op == OP_QUERY && !directed_rows[i].known) begin
        ask_box(directed_rows[i].item);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].res);
      end
    end
    settle();

    set_extents(6'd7, 6'd5, 6'd3);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);
    settle();
    // above the maximum, saturates to full size
    set_extents(6'd63, 6'd33, 6'd32);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    settle();
    set_extents(6'd2, 6'd2, 6'd2);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    settle();
    // writes outside the register list are dropped; zero width fails every box
    write_extent(REG_UNUSED_LO, 6'd5);
    write_extent(REG_UNUSED_HI, '1);
    set_extents(6'd0, 6'd12, 6'd9);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    settle();
    set_extents(EXT_W'($urandom_range(2, 32)), EXT_W'($urandom_range(2, 32)),
                EXT_W'($urandom_range(2, 32)));
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    settle();
    set_extents(6'd16, 6'd9, 6'd24);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);
    settle();

    $display("summary: %0d items (%0d loads, %0d box queries) over %0d extent settings",
             items_sent, loads_sent, queries_sent, settings_used + 1);
    $display("summary: %0d results checked, %0d of them range errors, %0d mismatches",
             results_checked, range_errors_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== integral_volume_box_sum.f =====
hw/rtl/ivbs_pkg.sv
hw/rtl/ivbs_cfg.sv
hw/rtl/ivbs_store.sv
hw/rtl/ivbs_seq.sv
hw/rtl/integral_volume_box_sum.sv
tb/sv/integral_volume_box_sum_tb.sv
